// ===== rtl/core/pfps_pkg.sv =====
// Shared types and constants for the profile feedforward PID step core.
package pfps_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned NumRegs = 7;
    localparam int unsigned AddrW   = 5;
    localparam int unsigned MulW    = 33;
    localparam int unsigned ProdW   = 2 * MulW;
    localparam int unsigned AccW    = 66;
    localparam int unsigned IntegW  = 48;
    localparam int unsigned FracW   = 16;
    localparam int unsigned InDataW  = 256;
    localparam int unsigned OutDataW = 96;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_GAIN_POSITION    = 3'd0,
        REG_GAIN_INTEGRAL    = 3'd1,
        REG_GAIN_VELOCITY    = 3'd2,
        REG_GAIN_FF_VELOCITY = 3'd3,
        REG_GAIN_FF_ACCEL    = 3'd4,
        REG_OUTPUT_FLOOR     = 3'd5,
        REG_OUTPUT_CEILING   = 3'd6
    } t_reg_idx;

    localparam logic signed [DataW-1:0] FloorReset = 32'sh8000_0000;
    localparam logic signed [DataW-1:0] CeilReset  = 32'sh7FFF_FFFF;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic signed [DataW-1:0] gain_position;
        logic signed [DataW-1:0] gain_integral;
        logic signed [DataW-1:0] gain_velocity;
        logic signed [DataW-1:0] gain_ff_velocity;
        logic signed [DataW-1:0] gain_ff_accel;
        logic signed [DataW-1:0] output_floor;
        logic signed [DataW-1:0] output_ceiling;
    } t_cfg;

    // Sequencer steps: each MUL step feeds the multiplier, the following step uses the product
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_ACC_P,
        ST_MUL_V,
        ST_ACC_V,
        ST_MUL_FV,
        ST_ACC_FV,
        ST_MUL_FA,
        ST_ACC_FA,
        ST_MUL_E,
        ST_INTEG,
        ST_MUL_LO,
        ST_HOLD_LO,
        ST_MUL_HI,
        ST_ACC_I,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/core/pfps_regs.sv =====
// APB-style configuration register file for the PID step core.
module pfps_regs
    import pfps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[AddrW-1:2]);
    assign o_cfg  = r_cfg;

    // Register writes; indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_position    <= '0;
            r_cfg.gain_integral    <= '0;
            r_cfg.gain_velocity    <= '0;
            r_cfg.gain_ff_velocity <= '0;
            r_cfg.gain_ff_accel    <= '0;
            r_cfg.output_floor     <= FloorReset;
            r_cfg.output_ceiling   <= CeilReset;
        end else if (wr_en) begin
            case (idx)
                REG_GAIN_POSITION:    r_cfg.gain_position    <= pwdata;
                REG_GAIN_INTEGRAL:    r_cfg.gain_integral    <= pwdata;
                REG_GAIN_VELOCITY:    r_cfg.gain_velocity    <= pwdata;
                REG_GAIN_FF_VELOCITY: r_cfg.gain_ff_velocity <= pwdata;
                REG_GAIN_FF_ACCEL:    r_cfg.gain_ff_accel    <= pwdata;
                REG_OUTPUT_FLOOR:     r_cfg.output_floor     <= pwdata;
                REG_OUTPUT_CEILING:   r_cfg.output_ceiling   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            REG_GAIN_POSITION:    prdata = r_cfg.gain_position;
            REG_GAIN_INTEGRAL:    prdata = r_cfg.gain_integral;
            REG_GAIN_VELOCITY:    prdata = r_cfg.gain_velocity;
            REG_GAIN_FF_VELOCITY: prdata = r_cfg.gain_ff_velocity;
            REG_GAIN_FF_ACCEL:    prdata = r_cfg.gain_ff_accel;
            REG_OUTPUT_FLOOR:     prdata = r_cfg.output_floor;
            REG_OUTPUT_CEILING:   prdata = r_cfg.output_ceiling;
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/pfps_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
module pfps_mul
    import pfps_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [MulW-1:0]  i_a,
    input  logic signed [MulW-1:0]  i_b,
    output logic signed [ProdW-1:0] o_prod
);

    logic signed [ProdW-1:0] r_prod;
    logic signed [ProdW-1:0] n_prod;

    assign n_prod = i_a * i_b;
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

endmodule

// ===== rtl/core/profile_feedforward_pid_step_core.sv =====
// Top level: PID step with feedforward and anti-windup, one shared multiplier under a sequencer.
//
//  channel  | dir | tdata fields (low bit up)                                | tuser
//  s_axis   | in  | now_time, measured_time, measured_position,              | accel_present
//           |     | measured_velocity, target_time, target_position,         |
//           |     | target_velocity, target_accel (8 x 32 bits)              |
//  m_axis   | out | drive, position_error, velocity_error (3 x 32 bits)      | integral_active
//  apb      | in  | seven 32-bit registers at byte address 4 * index         | -
//
// A transaction runs from acceptance through the sequencer steps to a valid result; the
// integral steps are skipped when the range test fails. The next input is taken only
// after the sequencer returns to idle. The single 33x33 multiplier forms all seven
// products, each followed by a step that uses the registered product.
// Reset (synchronous, active low) restores register defaults and clears the integral.
// Input is taken only while the sequencer is idle; a finished result waits in the
// output register, and the sequencer holds its last step until that register is free.
module profile_feedforward_pid_step_core
    import pfps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // stream input
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [InDataW-1:0]  i_s_axis_tdata,   // now_time, measured_time, measured_position,
                                                  // measured_velocity, target_time,
                                                  // target_position, target_velocity, target_accel
    input  logic                i_s_axis_tuser,   // accel_present
    // stream output
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OutDataW-1:0] o_m_axis_tdata,   // drive, position_error, velocity_error
    output logic                o_m_axis_tuser,   // integral_active
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_cfg cfg;

    pfps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Captured transaction
    logic        [DataW-1:0] r_now_t, r_meas_t, r_tgt_t;
    logic signed [DataW-1:0] r_meas_p, r_meas_v, r_tgt_p, r_tgt_v, r_tgt_a;
    logic                    r_acc_ok;

    // Working registers
    t_state                    r_state, n_state;
    logic signed [DataW-1:0]   r_pe, r_ve;
    logic        [DataW-1:0]   r_dt;
    logic signed [AccW-1:0]    r_acc;
    logic signed [IntegW-1:0]  r_integ;
    logic signed [IntegW:0]    r_part;
    logic                      r_active;
    logic                      r_have_prev;
    logic        [DataW-1:0]   r_prev_t;

    // Output register
    logic                      r_out_valid;
    logic signed [DataW-1:0]   r_out_drive, r_out_pe, r_out_ve;
    logic                      r_out_active;

    // Multiplier
    logic signed [MulW-1:0]    mul_a, mul_b;
    logic signed [ProdW-1:0]   prod;

    pfps_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Combinational helpers
    logic                      in_fire;
    logic                      out_free;
    logic signed [DataW:0]     pe_diff, ve_diff;
    logic signed [DataW-1:0]   pe_sat, ve_sat;
    logic        [DataW-1:0]   ref_t;
    logic signed [ProdW-FracW-1:0] prod_q;
    logic signed [AccW-1:0]    acc_add;
    logic signed [AccW-1:0]    floor_x, ceil_x;
    logic                      in_range;
    logic signed [IntegW+1:0]  integ_sum;
    logic signed [IntegW-1:0]  integ_sat;
    logic signed [79:0]        iterm_full;
    logic signed [AccW-1:0]    iterm;
    logic signed [DataW-1:0]   drive_clamp;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_fire         = i_s_axis_tvalid & o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Saturated errors and tick interval
    assign pe_diff = {r_tgt_p[DataW-1], r_tgt_p} - {r_meas_p[DataW-1], r_meas_p};
    assign ve_diff = {r_tgt_v[DataW-1], r_tgt_v} - {r_meas_v[DataW-1], r_meas_v};
    assign pe_sat  = (pe_diff[DataW] != pe_diff[DataW-1])
                   ? (pe_diff[DataW] ? FloorReset : CeilReset) : pe_diff[DataW-1:0];
    assign ve_sat  = (ve_diff[DataW] != ve_diff[DataW-1])
                   ? (ve_diff[DataW] ? FloorReset : CeilReset) : ve_diff[DataW-1:0];
    assign ref_t   = r_have_prev ? r_prev_t : r_meas_t;

    // Floored Q16.16 product and range test
    assign prod_q   = prod[ProdW-1:FracW];
    assign acc_add  = r_acc + AccW'(prod_q);
    assign floor_x  = AccW'(cfg.output_floor);
    assign ceil_x   = AccW'(cfg.output_ceiling);
    assign in_range = (r_acc >= floor_x) && (r_acc <= ceil_x);

    // Integral update with 48-bit saturation
    assign integ_sum = (IntegW+2)'(r_integ) + prod_q[IntegW+1:0];
    always_comb begin
        if (integ_sum > $signed({3'b000, {(IntegW-1){1'b1}}})) begin
            integ_sat = {1'b0, {(IntegW-1){1'b1}}};
        end else if (integ_sum < $signed({3'b111, {(IntegW-1){1'b0}}})) begin
            integ_sat = {1'b1, {(IntegW-1){1'b0}}};
        end else begin
            integ_sat = integ_sum[IntegW-1:0];
        end
    end

    // Integral term: (gain * hi) << 16 plus gain * lo, floored by 16
    assign iterm_full = (80'(prod) <<< FracW) + 80'(r_part);
    assign iterm      = AccW'($signed(iterm_full[79:FracW]));

    // Final clamp; an inverted range always yields the floor
    always_comb begin
        if (r_acc < floor_x || floor_x > ceil_x) begin
            drive_clamp = cfg.output_floor;
        end else if (r_acc > ceil_x) begin
            drive_clamp = cfg.output_ceiling;
        end else begin
            drive_clamp = r_acc[DataW-1:0];
        end
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MUL_P: begin
                mul_a = MulW'(cfg.gain_position);
                mul_b = MulW'(r_pe);
            end
            ST_MUL_V: begin
                mul_a = MulW'(cfg.gain_velocity);
                mul_b = MulW'(r_ve);
            end
            ST_MUL_FV: begin
                mul_a = MulW'(cfg.gain_ff_velocity);
                mul_b = MulW'(r_tgt_v);
            end
            ST_MUL_FA: begin
                mul_a = MulW'(cfg.gain_ff_accel);
                mul_b = r_acc_ok ? MulW'(r_tgt_a) : '0;
            end
            ST_MUL_E: begin
                mul_a = MulW'(r_pe);
                mul_b = {1'b0, r_dt};
            end
            ST_MUL_LO: begin
                mul_a = MulW'(cfg.gain_integral);
                mul_b = {{(MulW-FracW){1'b0}}, r_integ[FracW-1:0]};
            end
            ST_MUL_HI: begin
                mul_a = MulW'(cfg.gain_integral);
                mul_b = MulW'($signed(r_integ[IntegW-1:FracW]));
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_fire) n_state = ST_PREP;
            ST_PREP:    n_state = ST_MUL_P;
            ST_MUL_P:   n_state = ST_ACC_P;
            ST_ACC_P:   n_state = ST_MUL_V;
            ST_MUL_V:   n_state = ST_ACC_V;
            ST_ACC_V:   n_state = ST_MUL_FV;
            ST_MUL_FV:  n_state = ST_ACC_FV;
            ST_ACC_FV:  n_state = ST_MUL_FA;
            ST_MUL_FA:  n_state = ST_ACC_FA;
            ST_ACC_FA:  n_state = ST_MUL_E;
            ST_MUL_E:   n_state = ST_INTEG;
            ST_INTEG:   n_state = in_range ? ST_MUL_LO : ST_OUT;
            ST_MUL_LO:  n_state = ST_HOLD_LO;
            ST_HOLD_LO: n_state = ST_MUL_HI;
            ST_MUL_HI:  n_state = ST_ACC_I;
            ST_ACC_I:   n_state = ST_OUT;
            ST_OUT:     if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_integ     <= '0;
            r_have_prev <= 1'b0;
            r_prev_t    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_PREP) begin
                r_have_prev <= 1'b1;
                r_prev_t    <= r_tgt_t;
            end
            if (r_state == ST_INTEG) begin
                r_integ <= in_range ? integ_sat : '0;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_now_t  <= i_s_axis_tdata[31:0];
            r_meas_t <= i_s_axis_tdata[63:32];
            r_meas_p <= i_s_axis_tdata[95:64];
            r_meas_v <= i_s_axis_tdata[127:96];
            r_tgt_t  <= i_s_axis_tdata[159:128];
            r_tgt_p  <= i_s_axis_tdata[191:160];
            r_tgt_v  <= i_s_axis_tdata[223:192];
            r_tgt_a  <= i_s_axis_tdata[255:224];
            r_acc_ok <= i_s_axis_tuser;
        end
        unique case (r_state)
            ST_PREP: begin
                r_pe  <= pe_sat;
                r_ve  <= ve_sat;
                r_dt  <= (r_now_t >= ref_t) ? (r_now_t - ref_t) : '0;
                r_acc <= '0;
            end
            ST_ACC_P, ST_ACC_V, ST_ACC_FV, ST_ACC_FA: begin
                r_acc <= acc_add;
            end
            ST_INTEG: begin
                r_active <= in_range;
            end
            ST_HOLD_LO: begin
                r_part <= prod[IntegW:0];
            end
            ST_ACC_I: begin
                r_acc <= r_acc + iterm;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_drive  <= drive_clamp;
                    r_out_pe     <= r_pe;
                    r_out_ve     <= r_ve;
                    r_out_active <= r_active;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_ve, r_out_pe, r_out_drive};
    assign o_m_axis_tuser  = r_out_active;

endmodule

// ===== bench/tb_profile_feedforward_pid_step_core.sv =====
// Self-checking bench for the PID step core: directed table, random control ticks, APB gain loads.
module tb_profile_feedforward_pid_step_core
    import pfps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1_000_000;
    localparam int RandPhases = 19;
    localparam int TicksPerPhase = 100;
    localparam logic [2:0] RegUnmapped = 3'd7;

    // gain presets used by the directed table
    localparam int PRE_RESET    = 0;
    localparam int PRE_INTEG    = 1;
    localparam int PRE_MODERATE = 2;
    localparam int PRE_INVERTED = 3;
    localparam int PRE_EXTREME  = 4;

    typedef logic signed [127:0] t_wide;
    localparam t_wide IntegMax = 128'sd140737488355327;
    localparam t_wide IntegMin = -128'sd140737488355328;
    localparam t_wide Max32    = 128'sd2147483647;
    localparam t_wide Min32    = -128'sd2147483648;

    typedef struct packed {
        logic [31:0]        now_t;
        logic [31:0]        meas_t;
        logic signed [31:0] meas_p;
        logic signed [31:0] meas_v;
        logic [31:0]        tgt_t;
        logic signed [31:0] tgt_p;
        logic signed [31:0] tgt_v;
        logic signed [31:0] tgt_a;
        logic               accel_ok;
    } t_tick_in;

    typedef struct packed {
        logic [31:0] drive;
        logic [31:0] pos_err;
        logic [31:0] vel_err;
        logic        integ_on;
    } t_tick_out;

    typedef struct packed {
        t_tick_in  stim;
        int        preset;
        logic      typed;
        t_tick_out want;
    } t_tick_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [InDataW-1:0]  i_s_axis_tdata = '0;  // now_time, measured_time, measured_position,
                                               // measured_velocity, target_time,
                                               // target_position, target_velocity, target_accel
    logic                i_s_axis_tuser = 1'b0; // accel_present
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OutDataW-1:0] o_m_axis_tdata;       // drive, position_error, velocity_error
    logic                o_m_axis_tuser;       // integral_active
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrW-1:0]    paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    profile_feedforward_pid_step_core dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bench-side copy of the controller state and gains
    t_cfg        gains_now;
    t_wide       integ_acc = '0;
    logic        have_prev = 1'b0;
    logic [31:0] prev_tgt_t = '0;

    t_tick_out   pending_ticks[$];
    int          mismatch_count = 0;
    int          bench_cycles = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    logic [31:0] sim_clock = '0;
    logic signed [31:0] track_pos = '0;

    t_cfg presets [5] = '{
        '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, FloorReset, CeilReset},
        '{32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, FloorReset, CeilReset},
        '{32'sh0002_0000, 32'sh0000_8000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_4000,
          -32'sh0064_0000, 32'sh0064_0000},
        '{32'sh0002_0000, 32'sh0000_8000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_4000,
          32'sh0005_0000, -32'sh0005_0000},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          FloorReset, CeilReset}
    };

    // directed ticks; typed rows carry the result, the rest go through the predictor
    t_tick_row tick_table [20] = '{
        // first tick after reset: interval measured from measured_time
        '{'{32'h0002_0000, 32'h0001_0000, 32'sh0, 32'sh0, 32'h0002_0000, 32'sh0003_0000,
            32'sh0, 32'sh0, 1'b0}, PRE_INTEG, 1'b1, '{32'h0003_0000, 32'h0003_0000, 32'h0, 1'b1}},
        '{'{32'h0003_0000, 32'h0, 32'sh0001_0000, 32'sh0, 32'h0003_0000, 32'sh0,
            32'sh0, 32'sh0, 1'b0}, PRE_INTEG, 1'b0, '0},
        // error saturation, both signs
        '{'{32'h0, 32'h0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh0, 1'b0}, PRE_RESET, 1'b1,
          '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1}},
        '{'{32'h0, 32'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h0, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh0, 1'b0}, PRE_RESET, 1'b1,
          '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh0000_1234, 32'sh0, 32'hFFFF_FFFF, 32'sh0000_1234,
            32'sh0, 32'sh7FFF_FFFF, 1'b1}, PRE_RESET, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}},
        // time runs backward: interval floors at zero
        '{'{32'h0, 32'h0, 32'sh0, 32'sh0, 32'h0, 32'sh5, 32'sh0, 32'sh0, 1'b0},
          PRE_RESET, 1'b1, '{32'h0, 32'h5, 32'h0, 1'b1}},
        // huge interval drives the integral into positive saturation
        '{'{32'hFFFF_FFFF, 32'h0, 32'sh8000_0000, 32'sh0, 32'h0, 32'sh7FFF_FFFF,
            32'sh0, 32'sh0, 1'b0}, PRE_RESET, 1'b1, '{32'h0, 32'h7FFF_FFFF, 32'h0, 1'b1}},
        '{'{32'h0001_0000, 32'h0, 32'sh0, 32'sh0, 32'h0001_0000, 32'sh1, 32'sh0, 32'sh0, 1'b0},
          PRE_INTEG, 1'b0, '0},
        // then toward negative saturation
        '{'{32'hFFFF_FFFF, 32'h0, 32'sh7FFF_FFFF, 32'sh0, 32'h0, 32'sh8000_0000,
            32'sh0, 32'sh0, 1'b0}, PRE_INTEG, 1'b0, '0},
        '{'{32'hFFFF_FFFF, 32'h0, 32'sh7FFF_FFFF, 32'sh0, 32'h0, 32'sh8000_0000,
            32'sh0, 32'sh0, 1'b0}, PRE_INTEG, 1'b0, '0},
        // ordinary ticks, accel present and absent, then a clamp to the floor
        '{'{32'h0010_0000, 32'h000F_0000, 32'sh0001_8000, 32'sh0000_8000, 32'h0010_0000,
            32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b1}, PRE_MODERATE, 1'b0, '0},
        '{'{32'h0011_0000, 32'h0010_0000, 32'sh0001_C000, 32'sh0000_8000, 32'h0011_0000,
            32'sh0002_0000, 32'sh0001_0000, 32'sh7FFF_FFFF, 1'b0}, PRE_MODERATE, 1'b0, '0},
        '{'{32'h0012_0000, 32'h0011_0000, 32'sh0001_C000, 32'sh0000_8000, 32'h0012_0000,
            32'sh0002_0000, 32'sh0001_0000, 32'sh8000_0000, 1'b1}, PRE_MODERATE, 1'b0, '0},
        '{'{32'h0012_8000, 32'h0012_0000, 32'sh0002_0000, 32'sh0001_0000, 32'h0012_8000,
            32'sh0002_4000, 32'sh0001_0000, 32'sh0, 1'b1}, PRE_MODERATE, 1'b0, '0},
        // floor above ceiling: always the floor, integral cleared
        '{'{32'h0020_0000, 32'h0, 32'sh0, 32'sh0, 32'h0020_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0},
          PRE_INVERTED, 1'b1, '{32'h0005_0000, 32'h0, 32'h0, 1'b0}},
        '{'{32'h0021_0000, 32'h0, 32'sh0, 32'sh0, 32'h0021_0000, 32'sh0001_0000,
            32'sh0, 32'sh0, 1'b1}, PRE_INVERTED, 1'b1, '{32'h0005_0000, 32'h0001_0000, 32'h0, 1'b0}},
        // extreme gains
        '{'{32'h0022_0000, 32'h0, 32'sh0, 32'sh0, 32'h0022_0000, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1}, PRE_EXTREME, 1'b0, '0},
        '{'{32'h0023_0000, 32'h0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h0023_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 1'b1}, PRE_EXTREME, 1'b0, '0},
        '{'{32'h0024_0000, 32'h0, 32'sh0, 32'sh0, 32'h0024_0000, 32'sh1, 32'sh0, 32'sh0, 1'b1},
          PRE_EXTREME, 1'b0, '0},
        '{'{32'h0025_0000, 32'h0024_0000, 32'sh7FFF_FFFF, 32'sh0, 32'h0025_0000, 32'sh7FFF_FFF0,
            32'sh0, 32'sh0, 1'b0}, PRE_MODERATE, 1'b0, '0}
    };

    function automatic t_wide sat32(t_wide v);
        if (v > Max32) return Max32;
        if (v < Min32) return Min32;
        return v;
    endfunction

    // one control tick of the predictor: updates the bench state, returns the result
    function automatic t_tick_out control_tick(t_tick_in t);
        t_wide     nt, ref_t, dt, pe, ve, drv, acc, fl, cl;
        logic      active;
        t_tick_out r;
        nt    = t_wide'(t.now_t);
        ref_t = have_prev ? t_wide'(prev_tgt_t) : t_wide'(t.meas_t);
        dt    = (nt >= ref_t) ? nt - ref_t : t_wide'(0);
        pe    = sat32(t_wide'(t.tgt_p) - t_wide'(t.meas_p));
        ve    = sat32(t_wide'(t.tgt_v) - t_wide'(t.meas_v));
        fl    = t_wide'(gains_now.output_floor);
        cl    = t_wide'(gains_now.output_ceiling);
        drv   = ((t_wide'(gains_now.gain_position) * pe) >>> FracW)
              + ((t_wide'(gains_now.gain_velocity) * ve) >>> FracW)
              + ((t_wide'(gains_now.gain_ff_velocity) * t_wide'(t.tgt_v)) >>> FracW);
        if (t.accel_ok)
            drv = drv + ((t_wide'(gains_now.gain_ff_accel) * t_wide'(t.tgt_a)) >>> FracW);
        // anti-windup: integrate only while the unclamped drive is in range
        active = (drv >= fl) && (drv <= cl);
        if (active) begin
            acc = integ_acc + ((pe * dt) >>> FracW);
            if (acc > IntegMax) acc = IntegMax;
            if (acc < IntegMin) acc = IntegMin;
            integ_acc = acc;
            drv = drv + ((t_wide'(gains_now.gain_integral) * integ_acc) >>> FracW);
        end else begin
            integ_acc = '0;
        end
        if (drv > cl) drv = cl;
        if (drv < fl) drv = fl;
        prev_tgt_t = t.tgt_t;
        have_prev  = 1'b1;
        r.drive    = drv[31:0];
        r.pos_err  = pe[31:0];
        r.vel_err  = ve[31:0];
        r.integ_on = active;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [31:0] reg_word(t_cfg c, int idx);
        return c[(NumRegs - 1 - idx) * DataW +: DataW];
    endfunction

    // one APB transaction: setup cycle, then access until pready
    task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // write all gains, poke the unmapped slot, read everything back
    task automatic load_gains(t_cfg c);
        logic [31:0] rd;
        for (int i = 0; i < NumRegs; i++)
            apb_xfer(1'b1, 3'(i), reg_word(c, i), rd);
        apb_xfer(1'b1, RegUnmapped, $urandom, rd);
        for (int i = 0; i < NumRegs; i++) begin
            apb_xfer(1'b0, 3'(i), '0, rd);
            if (rd !== reg_word(c, i))
                report_mismatch($sformatf("register %0d readback", i), rd, reg_word(c, i));
        end
        gains_now = c;
    endtask

    // drop tvalid and wait for every outstanding result
    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (pending_ticks.size() != 0) @(negedge i_clk);
    endtask

    // offer one tick, predict it at the accepting edge
    task automatic send_tick(t_tick_in t, logic typed, t_tick_out want);
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  = {t.tgt_a, t.tgt_v, t.tgt_p, t.tgt_t,
                           t.meas_v, t.meas_p, t.meas_t, t.now_t};
        i_s_axis_tuser  = t.accel_ok;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        want = typed ? want : control_tick(t);
        if (typed) void'(control_tick(t));
        pending_ticks.push_back(want);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] near(int unsigned span);
        int v;
        v = int'($urandom_range(2 * span)) - int'(span);
        return v;
    endfunction

    // mostly a plausible servo trajectory, some pure noise
    function automatic t_tick_in make_tick();
        t_tick_in t;
        if ($urandom_range(99) < 20) begin
            t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, 1'($urandom)};
        end else begin
            sim_clock += ($urandom_range(99) < 5) ? $urandom : $urandom_range(1, 32'h2000);
            track_pos += near(32'h0002_0000);
            t.now_t    = sim_clock;
            t.meas_t   = sim_clock - $urandom_range(32'h400);
            t.tgt_t    = sim_clock - $urandom_range(32'h100);
            t.tgt_p    = track_pos;
            t.meas_p   = track_pos - near(($urandom_range(3) == 0) ? 32'h4_0000 : 32'h4000);
            t.tgt_v    = near(32'h0010_0000);
            t.meas_v   = t.tgt_v - near(32'h8000);
            t.tgt_a    = near(32'h0008_0000);
            t.accel_ok = 1'($urandom);
        end
        return t;
    endfunction

    // random gain set: mostly modest gains with ordered limits
    function automatic t_cfg pick_gains();
        t_cfg c;
        int unsigned k;
        k = $urandom_range(7);
        if (k == 0) begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (k == 1) begin
            for (int i = 0; i < NumRegs; i++)
                c[i * DataW +: DataW] = ($urandom_range(2) == 0) ? 32'h8000_0000 :
                                        ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
        end else begin
            c.gain_position    = near(32'h4_0000);
            c.gain_integral    = near(32'h4_0000);
            c.gain_velocity    = near(32'h4_0000);
            c.gain_ff_velocity = near(32'h4_0000);
            c.gain_ff_accel    = near(32'h4_0000);
            c.output_floor     = -int'($urandom_range(32'h0001_0000, 32'h0100_0000));
            c.output_ceiling   = $urandom_range(32'h0001_0000, 32'h0100_0000);
        end
        return c;
    endfunction

    // receiver backpressure
    always @(negedge i_clk)
        i_m_axis_tready = ($urandom_range(99) >= stall_pct);

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_tick_out want;
        if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (pending_ticks.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_axis_tdata[31:0], '0);
            end else begin
                want = pending_ticks.pop_front();
                if (o_m_axis_tdata[31:0] !== want.drive)
                    report_mismatch("drive", o_m_axis_tdata[31:0], want.drive);
                if (o_m_axis_tdata[63:32] !== want.pos_err)
                    report_mismatch("position_error", o_m_axis_tdata[63:32], want.pos_err);
                if (o_m_axis_tdata[95:64] !== want.vel_err)
                    report_mismatch("velocity_error", o_m_axis_tdata[95:64], want.vel_err);
                if (o_m_axis_tuser !== want.integ_on)
                    report_mismatch("integral_active", 32'(o_m_axis_tuser), 32'(want.integ_on));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        bench_cycles++;
        if (bench_cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int preset_now;
        gains_now  = presets[PRE_RESET];
        preset_now = PRE_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (tick_table[i]) begin
            if (tick_table[i].preset != preset_now) begin
                wait_drained();
                load_gains(presets[tick_table[i].preset]);
                preset_now = tick_table[i].preset;
            end
            send_tick(tick_table[i].stim, tick_table[i].typed, tick_table[i].want);
        end

        // random phases, cycling through the idle patterns
        for (int ph = 0; ph < RandPhases; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 57; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 57; end
                default: begin gap_pct = 7; stall_pct = 7; end
            endcase
            load_gains((ph == 0) ? presets[PRE_RESET] : pick_gains());
            repeat (TicksPerPhase) send_tick(make_tick(), 1'b0, '0);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
